[hw/rtl/gg2rc_pkg.sv]
// Shared types, constants and fit tables for the gripper goal to register counts block.
`default_nettype none

package gg2rc_pkg;

  // Field widths.
  localparam int GapW    = 18;
  localparam int OffW    = 19;
  localparam int SpeedW  = 20;
  localparam int EffortW = 17;
  localparam int CountW  = 8;
  localparam int StatusW = 3;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 20;

  // Effort of 1.0 in Q16.
  localparam logic [EffortW-1:0] EffortOne = 17'd65536;

  // Segment boundaries of the gap fit, in micrometres.
  localparam logic [GapW-1:0] SegLowUm  = 18'd100000;
  localparam logic [GapW-1:0] SegHighUm = 18'd134000;

  // Widths inside the gap mapping pipeline.
  localparam int SlopeW = 27;  // Q16 slope in counts per metre
  localparam int IcptW  = 45;  // Q16 intercept times one million
  localparam int ProdW  = SlopeW + GapW;
  localparam int NumW   = ProdW + 2;
  localparam int XW     = 28;  // numerator after dropping the Q16 fraction
  localparam int RecipW = 19;
  localparam int QW     = 10;

  // Division by one million as a multiply by floor(2^38 / 1e6), then one correction.
  localparam logic [RecipW-1:0] RecipM     = 19'd274877;
  localparam int                RecipShift = 38;
  localparam logic [19:0]       UmPerM     = 20'd1000000;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK     = 3'd0,
    ST_GAP    = 3'd1,
    ST_SPEED  = 3'd2,
    ST_EFFORT = 3'd3,
    ST_DIR    = 3'd4
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_GAP   = 2'd0,
    CFG_MAX_GAP   = 2'd1,
    CFG_MIN_SPEED = 2'd2,
    CFG_MAX_SPEED = 2'd3
  } cfg_idx_e;

  // Fit segments.
  typedef enum logic [1:0] {
    SEG_NARROW = 2'd0,
    SEG_MID    = 2'd1,
    SEG_WIDE   = 2'd2
  } seg_e;

  // Slope magnitude of each segment.
  function automatic logic [SlopeW-1:0] fit_slope(seg_e seg);
    logic [SlopeW-1:0] r;
    unique case (seg)
      SEG_NARROW: r = 27'd96948060;
      SEG_MID:    r = 27'd108909762;
      SEG_WIDE:   r = 27'd118678521;
      default:    r = 27'd118678521;
    endcase
    return r;
  endfunction

  // Intercept of each segment, scaled by one million.
  function automatic logic [IcptW-1:0] fit_icpt(seg_e seg);
    logic [IcptW-1:0] r;
    unique case (seg)
      SEG_NARROW: r = 45'd14866552000000;
      SEG_MID:    r = 45'd16099842000000;
      SEG_WIDE:   r = 45'd16868966000000;
      default:    r = 45'd16868966000000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/gg2rc_gap_map.sv]
// Four-stage pipeline that maps a gap in micrometres to a saturated position count.
`default_nettype none

module gg2rc_gap_map (
  input  wire logic                          clk_i,
  input  wire logic [gg2rc_pkg::GapW-1:0]    gap_i,
  output logic      [gg2rc_pkg::CountW-1:0]  count_o
);

  gg2rc_pkg::seg_e                    seg_d;
  gg2rc_pkg::seg_e                    seg_q;
  logic [gg2rc_pkg::ProdW-1:0]        prod_q;
  logic signed [gg2rc_pkg::NumW-1:0]  num_d;
  logic                               neg_q, neg2_q;
  logic [gg2rc_pkg::XW-1:0]           x_q, x2_q;
  logic [gg2rc_pkg::XW+gg2rc_pkg::RecipW-1:0] recip_prod;
  logic [gg2rc_pkg::QW-2:0]           q0_q;
  logic [gg2rc_pkg::QW-1:0]           q_inc;
  logic [29:0]                        next_bound;
  logic [gg2rc_pkg::QW-1:0]           q_d;
  logic [gg2rc_pkg::CountW-1:0]       count_d;

  // Pick the fit segment from the gap.
  always_comb begin
    if (gap_i <= gg2rc_pkg::SegLowUm) begin
      seg_d = gg2rc_pkg::SEG_NARROW;
    end else if (gap_i >= gg2rc_pkg::SegHighUm) begin
      seg_d = gg2rc_pkg::SEG_WIDE;
    end else begin
      seg_d = gg2rc_pkg::SEG_MID;
    end
  end

  // Stage 1: slope times gap.
  always_ff @(posedge clk_i) begin
    seg_q  <= seg_d;
    prod_q <= gg2rc_pkg::fit_slope(seg_d) * gap_i;
  end

  // Stage 2: intercept minus product, then drop the Q16 fraction.
  assign num_d = $signed({2'b00, gg2rc_pkg::fit_icpt(seg_q)}) - $signed({2'b00, prod_q});

  always_ff @(posedge clk_i) begin
    neg_q <= num_d[gg2rc_pkg::NumW-1];
    x_q   <= num_d[gg2rc_pkg::XW+15:16];
  end

  // Stage 3: quotient estimate by one million, low by at most one.
  assign recip_prod = x_q * gg2rc_pkg::RecipM;

  always_ff @(posedge clk_i) begin
    q0_q   <= recip_prod[gg2rc_pkg::RecipShift +: (gg2rc_pkg::QW-1)];
    x2_q   <= x_q;
    neg2_q <= neg_q;
  end

  // Stage 4: correct the estimate and saturate to the count range.
  always_comb begin
    q_inc      = {1'b0, q0_q} + 10'd1;
    next_bound = q_inc * gg2rc_pkg::UmPerM;
    q_d        = ({2'b00, x2_q} >= next_bound) ? q_inc : {1'b0, q0_q};
    if (neg2_q) begin
      count_d = '0;
    end else if (q_d > 10'd255) begin
      count_d = '1;
    end else begin
      count_d = q_d[gg2rc_pkg::CountW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    count_o <= count_d;
  end

endmodule

`default_nettype wire

[hw/rtl/gripper_goal_to_register_counts.sv]
// Top level: gripper command to position, speed and force register counts.
//
// A command is taken at each rising edge with start_i high and busy_o low;
// busy_o stays low, so a new command may follow in every cycle. After a
// command is taken, done_o is high for one cycle with the position,
// speed and force counts and the status of that command. Results leave in
// the order the commands came in and cannot be held off by the receiver.
// The latency is set by the position path: the gap is mapped once, the
// offset gap is built from that count, and the result is mapped again,
// each mapping being a four-stage multiply, subtract, reciprocal and
// correct pipeline. The speed count comes from an eight-stage restoring
// divider beside it. The user must write the gap and speed limits through
// the cfg_we_i port only while no command is in flight; the block does not
// enforce it. Reset clears the in-flight valid bits, loads default limits.
`default_nettype none

module gripper_goal_to_register_counts (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration writes.
  input  wire logic                             cfg_we_i,
  input  wire logic [gg2rc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [gg2rc_pkg::CfgW-1:0]       cfg_wdata_i,
  // Commands.
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [gg2rc_pkg::GapW-1:0]       target_gap_um_i,
  input  wire logic signed [gg2rc_pkg::OffW-1:0] gap_offset_um_i,
  input  wire logic [gg2rc_pkg::SpeedW-1:0]     speed_umps_i,
  input  wire logic [gg2rc_pkg::EffortW-1:0]    effort_q16_i,
  input  wire logic [gg2rc_pkg::CountW-1:0]     current_position_count_i,
  // Results.
  output logic                                  done_o,
  output logic [gg2rc_pkg::CountW-1:0]          position_count_o,
  output logic [gg2rc_pkg::CountW-1:0]          speed_count_o,
  output logic [gg2rc_pkg::CountW-1:0]          force_count_o,
  output logic [gg2rc_pkg::StatusW-1:0]         status_o
);

  localparam int NS         = 10;  // pipeline stages
  localparam int DivFirst   = 2;   // first divider stage
  localparam int ShiftStage = 5;   // stage that builds the offset gap
  localparam int RemW       = 28;

  typedef struct packed {
    gg2rc_pkg::status_e                  status;
    logic [gg2rc_pkg::GapW-1:0]          gap;
    logic signed [gg2rc_pkg::OffW-1:0]   off;
    logic [gg2rc_pkg::CountW-1:0]        cur;
    logic [gg2rc_pkg::CountW-1:0]        frc;
    logic [RemW-1:0]                     rem;
    logic [gg2rc_pkg::CountW-1:0]        quo;
    logic [gg2rc_pkg::CountW-1:0]        pos1;
    logic                                use_shift;
    logic [gg2rc_pkg::GapW-1:0]          shg;
  } carry_t;

  logic [gg2rc_pkg::GapW-1:0]   min_gap_q, max_gap_q;
  logic [gg2rc_pkg::SpeedW-1:0] min_speed_q, max_speed_q;
  logic [gg2rc_pkg::SpeedW-1:0] span;
  logic                         accept;
  logic [NS:1]                  valid_q;
  carry_t                       car_q [1:NS-1];
  carry_t                       car_d [2:NS-1];
  carry_t                       car1_d;
  logic [gg2rc_pkg::SpeedW-1:0] spd_diff;
  logic [24:0]                  frc_prod;
  logic [gg2rc_pkg::CountW-1:0] m1_cnt, m2_cnt;
  logic signed [19:0]           sh_raw, sh_hi;
  logic [gg2rc_pkg::GapW-1:0]   sh_gap;
  logic                         dir_err;
  logic [gg2rc_pkg::CountW-1:0] pos_d, spd_d, frc_d;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gap_q   <= 18'd0;
      max_gap_q   <= 18'd85000;
      min_speed_q <= 20'd20000;
      max_speed_q <= 20'd150000;
    end else if (cfg_we_i) begin
      unique case (gg2rc_pkg::cfg_idx_e'(cfg_idx_i))
        gg2rc_pkg::CFG_MIN_GAP:   min_gap_q   <= cfg_wdata_i[gg2rc_pkg::GapW-1:0];
        gg2rc_pkg::CFG_MAX_GAP:   max_gap_q   <= cfg_wdata_i[gg2rc_pkg::GapW-1:0];
        gg2rc_pkg::CFG_MIN_SPEED: min_speed_q <= cfg_wdata_i;
        gg2rc_pkg::CFG_MAX_SPEED: max_speed_q <= cfg_wdata_i;
      endcase
    end
  end

  assign span   = max_speed_q - min_speed_q;
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Stage 1: range checks, speed numerator and force count.
  always_comb begin
    car1_d = '0;
    if (target_gap_um_i > max_gap_q || target_gap_um_i < min_gap_q) begin
      car1_d.status = gg2rc_pkg::ST_GAP;
    end else if (speed_umps_i > max_speed_q || speed_umps_i < min_speed_q) begin
      car1_d.status = gg2rc_pkg::ST_SPEED;
    end else if (effort_q16_i > gg2rc_pkg::EffortOne) begin
      car1_d.status = gg2rc_pkg::ST_EFFORT;
    end else begin
      car1_d.status = gg2rc_pkg::ST_OK;
    end
    spd_diff     = speed_umps_i - min_speed_q;
    car1_d.rem   = ({8'd0, spd_diff} << 8) - {8'd0, spd_diff};
    frc_prod     = {8'd0, effort_q16_i} * 25'd255;
    car1_d.frc   = frc_prod[23:16];
    car1_d.gap   = target_gap_um_i;
    car1_d.off   = gap_offset_um_i;
    car1_d.cur   = current_position_count_i;
  end

  // First gap mapping, its count lines up with stage four.
  gg2rc_gap_map u_map_target (
    .clk_i   (clk_i),
    .gap_i   (target_gap_um_i),
    .count_o (m1_cnt)
  );

  // Offset gap: direction from the current count, then clamp to the limits.
  always_comb begin
    dir_err = (car_q[ShiftStage-1].cur == m1_cnt);
    if (car_q[ShiftStage-1].cur < m1_cnt) begin
      sh_raw = $signed({2'b00, car_q[ShiftStage-1].gap})
             - 20'(car_q[ShiftStage-1].off);
    end else begin
      sh_raw = $signed({2'b00, car_q[ShiftStage-1].gap})
             + 20'(car_q[ShiftStage-1].off);
    end
    sh_hi  = (sh_raw > $signed({2'b00, max_gap_q})) ? $signed({2'b00, max_gap_q}) : sh_raw;
    if (sh_hi < $signed({2'b00, min_gap_q})) begin
      sh_gap = min_gap_q;
    end else begin
      sh_gap = sh_hi[gg2rc_pkg::GapW-1:0];
    end
  end

  // Stages 2 to 9: one quotient bit per stage, offset gap at its stage.
  always_comb begin
    logic [RemW-1:0] den;
    for (int s = 2; s < NS; s++) begin
      car_d[s] = car_q[s-1];
      if (s >= DivFirst && s < DivFirst + gg2rc_pkg::CountW) begin
        den = {8'd0, span} << (DivFirst + gg2rc_pkg::CountW - 1 - s);
        if (car_q[s-1].rem >= den) begin
          car_d[s].rem = car_q[s-1].rem - den;
          car_d[s].quo = {car_q[s-1].quo[gg2rc_pkg::CountW-2:0], 1'b1};
        end else begin
          car_d[s].quo = {car_q[s-1].quo[gg2rc_pkg::CountW-2:0], 1'b0};
        end
      end
      if (s == ShiftStage) begin
        car_d[s].pos1      = m1_cnt;
        car_d[s].use_shift = (car_q[s-1].off != '0);
        car_d[s].shg       = sh_gap;
        if (car_q[s-1].status == gg2rc_pkg::ST_OK && car_q[s-1].off != '0 && dir_err) begin
          car_d[s].status = gg2rc_pkg::ST_DIR;
        end
      end
    end
  end

  // Valid bits travel beside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[NS-1:1], accept};
    end
  end

  // Payload stages.
  always_ff @(posedge clk_i) begin
    car_q[1] <= car1_d;
    for (int s = 2; s < NS; s++) begin
      car_q[s] <= car_d[s];
    end
  end

  // Second gap mapping on the offset gap, count lines up with the last carry stage.
  gg2rc_gap_map u_map_shift (
    .clk_i   (clk_i),
    .gap_i   (car_q[ShiftStage].shg),
    .count_o (m2_cnt)
  );

  // Final selection; every count is zero on an error.
  always_comb begin
    if (car_q[NS-1].status != gg2rc_pkg::ST_OK) begin
      pos_d = '0;
      spd_d = '0;
      frc_d = '0;
    end else begin
      pos_d = car_q[NS-1].use_shift ? m2_cnt : car_q[NS-1].pos1;
      spd_d = (span == '0) ? '0 : car_q[NS-1].quo;
      frc_d = car_q[NS-1].frc;
    end
  end

  always_ff @(posedge clk_i) begin
    position_count_o <= pos_d;
    speed_count_o    <= spd_d;
    force_count_o    <= frc_d;
    status_o         <= car_q[NS-1].status;
  end

  assign done_o = valid_q[NS];

  // A result appears exactly one latency after its command transfer.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, NS))
    else $error("result without a command transfer one latency earlier");

  // Error results carry no counts.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != gg2rc_pkg::ST_OK) |->
      (position_count_o == '0 && speed_count_o == '0 && force_count_o == '0))
    else $error("nonzero count on an error result");

  // An undetermined direction only arises with a nonzero offset.
  a_dir_needs_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == gg2rc_pkg::ST_DIR) |-> ($past(gap_offset_um_i, NS) != '0))
    else $error("direction error reported for a zero offset");

  // An accepted result had its speed inside the configured span.
  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == gg2rc_pkg::ST_OK) |->
      ($past(speed_umps_i, NS) >= min_speed_q && $past(speed_umps_i, NS) <= max_speed_q))
    else $error("ok status for a speed outside the limits");

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Testbench for the gripper command to register counts block.
`timescale 1ns / 1ps

module tb_top;
  import gg2rc_pkg::*;

  // Fit coefficients in Q16: slope magnitude in counts per metre, intercept in counts.
  localparam longint SlopeNarrow = 96948060;
  localparam longint IcptNarrow  = 14866552;
  localparam longint SlopeMid    = 108909762;
  localparam longint IcptMid     = 16099842;
  localparam longint SlopeWide   = 118678521;
  localparam longint IcptWide    = 16868966;
  localparam longint NarrowMaxUm = 100000;
  localparam longint WideMinUm   = 134000;
  localparam longint UmPerMetre  = 1000000;
  localparam longint Q16Scale    = 65536;
  localparam int     CycleLimit  = 200000;
  localparam int     SettleCycles = 15;

  // One command as it is presented to the block.
  typedef struct {
    logic [GapW-1:0]        gap_um;
    logic signed [OffW-1:0] offset_um;
    logic [SpeedW-1:0]      speed_umps;
    logic [EffortW-1:0]     effort_q16;
    logic [CountW-1:0]      cur_count;
  } cmd_t;

  // The counts and status that one command must produce.
  typedef struct {
    logic [CountW-1:0] pos_count;
    logic [CountW-1:0] spd_count;
    logic [CountW-1:0] frc_count;
    status_e           status;
  } counts_t;

  // Actions the command driver works through in order.
  typedef enum logic [1:0] {
    ACT_CMD,
    ACT_CFG,
    ACT_DRAIN,
    ACT_RATE
  } act_e;

  typedef struct {
    act_e          act;
    cmd_t          cmd;
    cfg_idx_e      idx;
    logic [CfgW-1:0] value;
    int unsigned   rate;
  } plan_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx_i = '0;
  logic [CfgW-1:0]        cfg_wdata_i = '0;
  logic                   start_i = 1'b0;
  logic                   busy_o;
  logic [GapW-1:0]        target_gap_um_i = '0;
  logic signed [OffW-1:0] gap_offset_um_i = '0;
  logic [SpeedW-1:0]      speed_umps_i = '0;
  logic [EffortW-1:0]     effort_q16_i = '0;
  logic [CountW-1:0]      current_position_count_i = '0;
  logic                   done_o;
  logic [CountW-1:0]      position_count_o;
  logic [CountW-1:0]      speed_count_o;
  logic [CountW-1:0]      force_count_o;
  logic [StatusW-1:0]     status_o;

  // Limits as the block should hold them, and the copy the stimulus builder works from.
  logic [GapW-1:0]   lim_min_gap;
  logic [GapW-1:0]   lim_max_gap;
  logic [SpeedW-1:0] lim_min_speed;
  logic [SpeedW-1:0] lim_max_speed;
  int unsigned gen_min_gap = 0;
  int unsigned gen_max_gap = 85000;
  int unsigned gen_min_speed = 20000;
  int unsigned gen_max_speed = 150000;

  plan_t       cmd_backlog[$];
  counts_t     counts_due[$];
  logic        cmd_taken = 1'b0;
  int unsigned sender_idle_pct = 0;
  int unsigned mismatch_count = 0;

  gripper_goal_to_register_counts DUT (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_we_i                 (cfg_we_i),
    .cfg_idx_i                (cfg_idx_i),
    .cfg_wdata_i              (cfg_wdata_i),
    .start_i                  (start_i),
    .busy_o                   (busy_o),
    .target_gap_um_i          (target_gap_um_i),
    .gap_offset_um_i          (gap_offset_um_i),
    .speed_umps_i             (speed_umps_i),
    .effort_q16_i             (effort_q16_i),
    .current_position_count_i (current_position_count_i),
    .done_o                   (done_o),
    .position_count_o         (position_count_o),
    .speed_count_o            (speed_count_o),
    .force_count_o            (force_count_o),
    .status_o                 (status_o)
  );

  // Clock and a single reset pulse.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Three-segment linear fit from a gap in micrometres to a position count.
  function automatic logic [CountW-1:0] gap_fit_count(longint g);
    longint slope;
    longint icpt;
    longint num;
    longint q;
    if (g <= NarrowMaxUm) begin
      slope = SlopeNarrow;
      icpt = IcptNarrow;
    end else if (g >= WideMinUm) begin
      slope = SlopeWide;
      icpt = IcptWide;
    end else begin
      slope = SlopeMid;
      icpt = IcptMid;
    end
    num = icpt * UmPerMetre - slope * g;
    if (num <= 0) begin
      return '0;
    end
    q = num / (Q16Scale * UmPerMetre);
    if (q > 255) begin
      q = 255;
    end
    return CountW'(q);
  endfunction

  // Expected counts for one command under the current limits.
  function automatic counts_t predict_counts(cmd_t c);
    counts_t r;
    longint gap;
    longint off;
    longint shifted;
    longint lo;
    longint hi;
    longint smin;
    longint smax;
    longint spd;
    longint eff;
    logic [CountW-1:0] pos;
    gap = c.gap_um;
    off = c.offset_um;
    spd = c.speed_umps;
    eff = c.effort_q16;
    lo = lim_min_gap;
    hi = lim_max_gap;
    smin = lim_min_speed;
    smax = lim_max_speed;
    r.pos_count = '0;
    r.spd_count = '0;
    r.frc_count = '0;
    r.status = ST_OK;
    if (gap > hi || gap < lo) begin
      r.status = ST_GAP;
    end else if (spd > smax || spd < smin) begin
      r.status = ST_SPEED;
    end else if (eff > Q16Scale) begin
      r.status = ST_EFFORT;
    end else begin
      pos = gap_fit_count(gap);
      if (off != 0 && c.cur_count == pos) begin
        // No direction of travel can be told, so the offset has no sign.
        r.status = ST_DIR;
      end else begin
        if (off != 0) begin
          // Closing narrows the gap by the offset, opening widens it.
          shifted = (c.cur_count < pos) ? gap - off : gap + off;
          if (shifted > hi) shifted = hi;
          if (shifted < lo) shifted = lo;
          pos = gap_fit_count(shifted);
        end
        r.pos_count = pos;
        r.spd_count = (smax == smin) ? '0 : CountW'(((spd - smin) * 255) / (smax - smin));
        r.frc_count = CountW'((eff * 255) / Q16Scale);
      end
    end
    return r;
  endfunction

  task automatic queue_cmd(int unsigned gap, int off, int unsigned spd, int unsigned eff,
                           int unsigned cur);
    plan_t p;
    p.act = ACT_CMD;
    p.cmd.gap_um = gap[GapW-1:0];
    p.cmd.offset_um = off[OffW-1:0];
    p.cmd.speed_umps = spd[SpeedW-1:0];
    p.cmd.effort_q16 = eff[EffortW-1:0];
    p.cmd.cur_count = cur[CountW-1:0];
    p.idx = CFG_MIN_GAP;
    p.value = '0;
    p.rate = 0;
    cmd_backlog.push_back(p);
  endtask

  task automatic queue_marker(act_e act, int unsigned rate);
    plan_t p;
    p = '{default: '0, act: act, idx: CFG_MIN_GAP, rate: rate};
    cmd_backlog.push_back(p);
  endtask

  task automatic queue_write(cfg_idx_e idx, int unsigned value);
    plan_t p;
    p = '{default: '0, act: ACT_CFG, idx: idx, rate: 0};
    p.value = value[CfgW-1:0];
    cmd_backlog.push_back(p);
  endtask

  // Wait for the block to empty, then load all four limits.
  task automatic queue_limits(int unsigned min_gap, int unsigned max_gap,
                              int unsigned min_spd, int unsigned max_spd);
    queue_marker(ACT_DRAIN, 0);
    queue_write(CFG_MIN_GAP, min_gap);
    queue_write(CFG_MAX_GAP, max_gap);
    queue_write(CFG_MIN_SPEED, min_spd);
    queue_write(CFG_MAX_SPEED, max_spd);
    gen_min_gap = min_gap;
    gen_max_gap = max_gap;
    gen_min_speed = min_spd;
    gen_max_speed = max_spd;
  endtask

  // Mostly commands that pass every check, the rest broken or fully random.
  task automatic queue_random_cmd();
    int unsigned lo;
    int unsigned hi;
    int unsigned gap;
    int unsigned spd;
    int unsigned eff;
    int unsigned cur;
    int unsigned pick;
    int          off;
    lo = (gen_min_gap <= gen_max_gap) ? gen_min_gap : gen_max_gap;
    hi = (gen_min_gap <= gen_max_gap) ? gen_max_gap : gen_min_gap;
    pick = $urandom_range(9);
    gap = (pick == 0) ? lo : (pick == 1) ? hi : $urandom_range(hi, lo);
    pick = $urandom_range(9);
    spd = (pick == 0) ? gen_min_speed : (pick == 1) ? gen_max_speed :
          $urandom_range(gen_max_speed, gen_min_speed);
    pick = $urandom_range(9);
    eff = (pick == 0) ? 65536 : (pick == 1) ? 0 : $urandom_range(65536, 0);
    pick = $urandom_range(9);
    if (pick < 2) begin
      off = 0;
    end else if (pick < 7) begin
      off = $urandom_range(20000, 1);
    end else begin
      off = $urandom_range(200000, 1);
    end
    if ($urandom_range(1) == 1) off = -off;
    pick = $urandom_range(9);
    cur = (pick < 2) ? gap_fit_count(gap) : $urandom_range(255);
    // Noise: break one check or scramble every field.
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(3))
        0: gap = $urandom & 32'h3FFFF;
        1: spd = $urandom & 32'hFFFFF;
        2: eff = $urandom_range(131071, 65537);
        default: begin
          gap = $urandom & 32'h3FFFF;
          off = $urandom;
          spd = $urandom & 32'hFFFFF;
          eff = $urandom & 32'h1FFFF;
          cur = $urandom_range(255);
        end
      endcase
    end
    queue_cmd(gap, off, spd, eff, cur);
  endtask

  // Command driver: presents the backlog at the falling edge.
  always @(negedge clk_i) begin : drive_cmds
    logic nxt_start;
    logic nxt_we;
    plan_t head;
    nxt_start = 1'b0;
    nxt_we = 1'b0;
    if (start_i && !cmd_taken) begin
      // The last transfer has not happened yet, so hold the command.
      nxt_start = 1'b1;
    end else if (rst_ni && cmd_backlog.size() != 0) begin
      head = cmd_backlog[0];
      case (head.act)
        ACT_RATE: begin
          sender_idle_pct = head.rate;
          void'(cmd_backlog.pop_front());
        end
        ACT_DRAIN: begin
          if (counts_due.size() == 0) void'(cmd_backlog.pop_front());
        end
        ACT_CFG: begin
          nxt_we = 1'b1;
          cfg_idx_i <= head.idx;
          cfg_wdata_i <= head.value;
          void'(cmd_backlog.pop_front());
        end
        default: begin
          if ($urandom_range(99) >= sender_idle_pct) begin
            nxt_start = 1'b1;
            target_gap_um_i <= head.cmd.gap_um;
            gap_offset_um_i <= head.cmd.offset_um;
            speed_umps_i <= head.cmd.speed_umps;
            effort_q16_i <= head.cmd.effort_q16;
            current_position_count_i <= head.cmd.cur_count;
            void'(cmd_backlog.pop_front());
          end
        end
      endcase
    end
    start_i <= nxt_start;
    cfg_we_i <= nxt_we;
  end

  task automatic log_mismatch(string what, longint want, longint got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  // Monitor: tracks limit writes, predicts each transfer and checks each result.
  always @(posedge clk_i) begin : check_counts
    counts_t want;
    cmd_t    seen;
    if (!rst_ni) begin
      lim_min_gap = 18'd0;
      lim_max_gap = 18'd85000;
      lim_min_speed = 20'd20000;
      lim_max_speed = 20'd150000;
      cmd_taken <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_GAP:   lim_min_gap = cfg_wdata_i[GapW-1:0];
          CFG_MAX_GAP:   lim_max_gap = cfg_wdata_i[GapW-1:0];
          CFG_MIN_SPEED: lim_min_speed = cfg_wdata_i;
          default:       lim_max_speed = cfg_wdata_i;
        endcase
      end
      if (done_o === 1'b1) begin
        if (counts_due.size() == 0) begin
          log_mismatch("result with no command pending, status", -1, status_o);
        end else begin
          want = counts_due.pop_front();
          if (position_count_o !== want.pos_count)
            log_mismatch("position_count", want.pos_count, position_count_o);
          if (speed_count_o !== want.spd_count)
            log_mismatch("speed_count", want.spd_count, speed_count_o);
          if (force_count_o !== want.frc_count)
            log_mismatch("force_count", want.frc_count, force_count_o);
          if (status_o !== want.status)
            log_mismatch("status", want.status, status_o);
        end
      end
      if (start_i && !busy_o) begin
        seen.gap_um = target_gap_um_i;
        seen.offset_um = gap_offset_um_i;
        seen.speed_umps = speed_umps_i;
        seen.effort_q16 = effort_q16_i;
        seen.cur_count = current_position_count_i;
        counts_due.push_back(predict_counts(seen));
      end
      cmd_taken <= start_i && !busy_o;
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Stimulus plan and end of run.
  initial begin : run_plan
    int unsigned k;
    int unsigned a;
    int unsigned b;
    int unsigned c;
    int unsigned d;
    queue_marker(ACT_RATE, 20);
    // Reset limits: field extremes, check order, direction and clamping.
    queue_cmd(0, 0, 20000, 0, 0);
    queue_cmd(85000, 0, 150000, 65536, 255);
    queue_cmd(85001, 0, 80000, 30000, 10);
    queue_cmd(262143, 0, 80000, 30000, 10);
    queue_cmd(40000, 0, 19999, 30000, 10);
    queue_cmd(40000, 0, 1048575, 30000, 10);
    queue_cmd(40000, 0, 80000, 65537, 10);
    queue_cmd(40000, 0, 80000, 131071, 10);
    queue_cmd(90000, 0, 0, 131071, 10);
    queue_cmd(40000, 0, 200000, 131071, 10);
    queue_cmd(0, 1000, 80000, 30000, 226);
    queue_cmd(40000, 5000, 80000, 30000, 0);
    queue_cmd(40000, 5000, 80000, 30000, 255);
    queue_cmd(40000, -200000, 80000, 30000, 0);
    queue_cmd(40000, 200000, 80000, 30000, 0);
    queue_cmd(40000, -262144, 80000, 30000, 255);
    queue_cmd(40000, 262143, 100000, 65535, 255);
    // Widest limits: segment boundaries and a fit that goes negative.
    queue_limits(0, 200000, 0, 1000000);
    queue_cmd(100000, 0, 0, 0, 0);
    queue_cmd(100001, 0, 1000000, 65536, 0);
    queue_cmd(133999, 0, 500000, 1, 0);
    queue_cmd(134000, 0, 999999, 65535, 0);
    queue_cmd(200000, 0, 1000000, 65536, 0);
    queue_cmd(150000, -30000, 0, 0, 255);
    for (k = 0; k < 110; k++) queue_random_cmd();
    queue_limits(30000, 140000, 10000, 300000);
    for (k = 0; k < 110; k++) begin
      // Hold off once mid-phase until the block is empty.
      if (k == 55) queue_marker(ACT_DRAIN, 0);
      queue_random_cmd();
    end
    queue_marker(ACT_RATE, 88);
    // Equal gap limits and a zero speed span.
    queue_limits(100000, 100000, 50000, 50000);
    for (k = 0; k < 110; k++) queue_random_cmd();
    // Crossed gap limits: every command fails the gap check.
    queue_limits(120000, 60000, 0, 1000000);
    for (k = 0; k < 60; k++) queue_random_cmd();
    queue_marker(ACT_RATE, 0);
    a = $urandom_range(200000);
    b = $urandom_range(200000);
    c = $urandom_range(1000000);
    d = $urandom_range(1000000);
    queue_limits(a < b ? a : b, a < b ? b : a, c < d ? c : d, c < d ? d : c);
    for (k = 0; k < 110; k++) queue_random_cmd();
    queue_limits(0, 85000, 20000, 150000);
    for (k = 0; k < 110; k++) queue_random_cmd();

    while (cmd_backlog.size() != 0 || start_i || counts_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
